@@ sv/eic_pkg.sv @@
// shared types, codes and sizes of the external interrupt controller
`default_nettype none

package eic_pkg;

  localparam int NUM_LINES        = 16;
  localparam int PORT_SELECT_BITS = 4;
  localparam int DATA_W           = 16;
  localparam int CODE_FIELD_W     = 4;
  localparam int WORD_LINES       = DATA_W / CODE_FIELD_W;

  localparam int S_TDATA_W = 120;
  localparam int M_TDATA_W = 56;

  localparam logic [DATA_W-1:0] LINE_MASK = DATA_W'((33'd1 << NUM_LINES) - 33'd1);

  typedef logic [PORT_SELECT_BITS-1:0] port_code_t;

  localparam port_code_t PORT_A = port_code_t'(0);
  localparam port_code_t PORT_B = port_code_t'(1);
  localparam port_code_t PORT_C = port_code_t'(2);
  localparam port_code_t PORT_D = port_code_t'(3);
  localparam port_code_t PORT_E = port_code_t'(4);
  localparam port_code_t PORT_H = port_code_t'(7);

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  localparam logic [3:0] ADDR_IMASK = 4'd0;
  localparam logic [3:0] ADDR_EMASK = 4'd1;
  localparam logic [3:0] ADDR_RISE  = 4'd2;
  localparam logic [3:0] ADDR_FALL  = 4'd3;
  localparam logic [3:0] ADDR_SWTRG = 4'd4;
  localparam logic [3:0] ADDR_PEND  = 4'd5;
  localparam logic [3:0] ADDR_SEL0  = 4'd6;
  localparam logic [3:0] ADDR_SEL3  = 4'd9;

  typedef struct packed {
    func_t             func;
    logic [3:0]        reg_addr;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] pins_a;
    logic [DATA_W-1:0] pins_b;
    logic [DATA_W-1:0] pins_c;
    logic [DATA_W-1:0] pins_d;
    logic [DATA_W-1:0] pins_e;
    logic [DATA_W-1:0] pins_h;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] irq_lines;
    logic [DATA_W-1:0] event_pulses;
    logic              bad_address;
  } result_t;

endpackage

`default_nettype wire

@@ sv/eic_pin_mux.sv @@
// per-line pin selection: picks each line's pin from the port its code names
`default_nettype none

module eic_pin_mux
  import eic_pkg::*;
(
  input  wire item_t                      item,
  input  wire logic [NUM_LINES*PORT_SELECT_BITS-1:0] codes,
  output logic [DATA_W-1:0]               levels
);

  for (genvar i = 0; i < DATA_W; i++) begin : g_line
    if (i < NUM_LINES) begin : g_used
      port_code_t code;
      assign code = codes[i*PORT_SELECT_BITS +: PORT_SELECT_BITS];
      always_comb begin
        case (code)
          PORT_A:  levels[i] = item.pins_a[i];
          PORT_B:  levels[i] = item.pins_b[i];
          PORT_C:  levels[i] = item.pins_c[i];
          PORT_D:  levels[i] = item.pins_d[i];
          PORT_E:  levels[i] = item.pins_e[i];
          PORT_H:  levels[i] = item.pins_h[i];
          default: levels[i] = 1'b0;
        endcase
      end
    end else begin : g_unused
      assign levels[i] = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ sv/eic_core.sv @@
// register file, edge detect and pending/event logic of the controller
`default_nettype none

module eic_core
  import eic_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  step,
  input  wire item_t item,
  output result_t    res
);

  logic [DATA_W-1:0] interrupt_mask, interrupt_mask_next;
  logic [DATA_W-1:0] event_mask, event_mask_next;
  logic [DATA_W-1:0] rising_select, rising_select_next;
  logic [DATA_W-1:0] falling_select, falling_select_next;
  logic [DATA_W-1:0] software_trigger, software_trigger_next;
  logic [DATA_W-1:0] pending_flags, pending_flags_next;
  logic [DATA_W-1:0] previous_levels, previous_levels_next;
  port_code_t        line_port_select [NUM_LINES];

  logic [NUM_LINES*PORT_SELECT_BITS-1:0] codes;
  logic [WORD_LINES*DATA_W-1:0]          code_words;
  logic [DATA_W-1:0]                     levels;
  logic [DATA_W-1:0]                     data;
  logic [DATA_W-1:0]                     fresh;
  logic [DATA_W-1:0]                     trig;
  logic [DATA_W-1:0]                     events;
  logic [DATA_W-1:0]                     rd;
  logic                                  bad;
  logic [1:0]                            word_sel;
  logic                                  sel_write;

  for (genvar i = 0; i < DATA_W; i++) begin : g_codes
    if (i < NUM_LINES) begin : g_used
      assign codes[i*PORT_SELECT_BITS +: PORT_SELECT_BITS] = line_port_select[i];
      assign code_words[i*CODE_FIELD_W +: CODE_FIELD_W]    =
        CODE_FIELD_W'(line_port_select[i]);
    end else begin : g_unused
      assign code_words[i*CODE_FIELD_W +: CODE_FIELD_W] = '0;
    end
  end

  eic_pin_mux u_pin_mux (
    .item   (item),
    .codes  (codes),
    .levels (levels)
  );

  assign data     = item.write_data & LINE_MASK;
  assign word_sel = 2'(item.reg_addr - ADDR_SEL0);
  assign fresh    = data & ~software_trigger;
  assign trig     = ((levels & ~previous_levels & rising_select) |
                     (~levels & previous_levels & falling_select)) & LINE_MASK;

  always_comb begin
    interrupt_mask_next   = interrupt_mask;
    event_mask_next       = event_mask;
    rising_select_next    = rising_select;
    falling_select_next   = falling_select;
    software_trigger_next = software_trigger;
    pending_flags_next    = pending_flags;
    previous_levels_next  = previous_levels;
    events                = '0;
    rd                    = '0;
    bad                   = 1'b0;
    sel_write             = 1'b0;
    case (item.func)
      FUNC_READ: begin
        case (item.reg_addr) inside
          ADDR_IMASK:            rd = interrupt_mask;
          ADDR_EMASK:            rd = event_mask;
          ADDR_RISE:             rd = rising_select;
          ADDR_FALL:             rd = falling_select;
          ADDR_SWTRG:            rd = software_trigger;
          ADDR_PEND:             rd = pending_flags;
          [ADDR_SEL0:ADDR_SEL3]: rd = code_words[word_sel*DATA_W +: DATA_W];
          default:               bad = 1'b1;
        endcase
      end
      FUNC_WRITE: begin
        case (item.reg_addr) inside
          ADDR_IMASK: interrupt_mask_next = data;
          ADDR_EMASK: event_mask_next     = data;
          ADDR_RISE:  rising_select_next  = data;
          ADDR_FALL:  falling_select_next = data;
          ADDR_SWTRG: begin
            // only bits going from 0 to 1 fire
            software_trigger_next = software_trigger | fresh;
            pending_flags_next    = pending_flags | (fresh & interrupt_mask);
            events                = fresh & event_mask;
          end
          ADDR_PEND: begin
            pending_flags_next    = pending_flags & ~data;
            software_trigger_next = software_trigger & ~data;
          end
          [ADDR_SEL0:ADDR_SEL3]: sel_write = 1'b1;
          default:               bad = 1'b1;
        endcase
      end
      FUNC_TICK: begin
        pending_flags_next   = pending_flags | trig;
        events               = trig & event_mask;
        previous_levels_next = levels;
      end
      default: begin
      end
    endcase
  end

  assign res.read_data    = rd;
  assign res.irq_lines    = pending_flags_next & interrupt_mask_next;
  assign res.event_pulses = events;
  assign res.bad_address  = bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      interrupt_mask   <= '0;
      event_mask       <= '0;
      rising_select    <= '0;
      falling_select   <= '0;
      software_trigger <= '0;
      pending_flags    <= '0;
      previous_levels  <= '0;
    end else if (step) begin
      interrupt_mask   <= interrupt_mask_next;
      event_mask       <= event_mask_next;
      rising_select    <= rising_select_next;
      falling_select   <= falling_select_next;
      software_trigger <= software_trigger_next;
      pending_flags    <= pending_flags_next;
      previous_levels  <= previous_levels_next;
    end
  end

  for (genvar i = 0; i < NUM_LINES; i++) begin : g_sel
    localparam int WORD = i / WORD_LINES;
    localparam int SLOT = i % WORD_LINES;
    always_ff @(posedge clk) begin
      if (rst) begin
        line_port_select[i] <= PORT_A;
      end else if (step && sel_write && (int'(word_sel) == WORD)) begin
        line_port_select[i] <= item.write_data[SLOT*CODE_FIELD_W +: PORT_SELECT_BITS];
      end
    end
  end

  // a tick leaves the sampled levels behind for the next edge compare
  a_levels_kept: assert property (@(posedge clk) disable iff (rst)
    step && item.func == FUNC_TICK |=> previous_levels == $past(levels))
    else $error("previous levels not taken from tick");

  // a pending clear write leaves no written bit pending
  a_pend_clear: assert property (@(posedge clk) disable iff (rst)
    step && item.func == FUNC_WRITE && item.reg_addr == ADDR_PEND |=>
    (pending_flags & $past(data)) == '0)
    else $error("pending bit survived clear");

  // a bad access changes no state
  a_bad_quiet: assert property (@(posedge clk) disable iff (rst)
    step && res.bad_address |=>
    $stable(interrupt_mask) && $stable(pending_flags) && $stable(software_trigger))
    else $error("bad access changed state");

  // events only fire on lines the event mask lets through
  a_event_masked: assert property (@(posedge clk) disable iff (rst)
    step |-> (res.event_pulses & ~event_mask) == '0)
    else $error("event on masked line");

endmodule

`default_nettype wire

@@ sv/external_interrupt_controller.sv @@
// top level: stream ports, input register, core and result register
// Sixteen-line external interrupt and event controller. Every input beat is
// a bus read, a bus write, a pin sampling tick or a no-op; every beat
// yields exactly one result beat, in order. A beat sits in the input
// register while the core works it out, and the result register catches
// the answer once that register is free and holds it until the sink takes
// it. One beat is taken every cycle while the sink keeps up; a stalled sink
// backs up through both registers and s_axis_tready drops only when both
// are full. All lines are handled in parallel in the core; there is no
// sequencing inside a beat.
// Each line watches the pin with its own number on the port picked by its
// port select code (A..E, H; other codes read low). After reset all masks,
// pending flags and previous levels are zero, so a high pin on the first
// tick looks like a rising edge. Writing 1 to a pending bit clears it along
// with its software trigger bit; accesses to words 10..15 set bad_address
// and change nothing.
`default_nettype none

module external_interrupt_controller
  import eic_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // func[1:0], reg_addr[5:2], write_data[21:6], pins_a[37:22], pins_b[53:38],
  // pins_c[69:54], pins_d[85:70], pins_e[101:86], pins_h[117:102], zero pad
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // read_data[15:0], irq_lines[31:16], event_pulses[47:32],
  // bad_address[48], zero pad
  output logic [M_TDATA_W-1:0]      m_axis_tdata
);

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  result_t res;
  logic    out_free;
  logic    step;

  // result register frees up when empty or being drained this cycle
  assign out_free      = !out_valid || m_axis_tready;
  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
  end

  // input payload capture
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.func       <= func_t'(s_axis_tdata[1:0]);
      in_item.reg_addr   <= s_axis_tdata[5:2];
      in_item.write_data <= s_axis_tdata[21:6];
      in_item.pins_a     <= s_axis_tdata[37:22];
      in_item.pins_b     <= s_axis_tdata[53:38];
      in_item.pins_c     <= s_axis_tdata[69:54];
      in_item.pins_d     <= s_axis_tdata[85:70];
      in_item.pins_e     <= s_axis_tdata[101:86];
      in_item.pins_h     <= s_axis_tdata[117:102];
    end
  end

  eic_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_res.bad_address, out_res.event_pulses,
                          out_res.irq_lines, out_res.read_data};

endmodule

`default_nettype wire
